// ===== rtl/bis_pkg.sv =====
package bis_pkg;

   // Frame store geometry. The store is split into four banks by row and
   // column parity so that the four neighbors of a sample are read at once.
   localparam int MAX_WIDTH  = 256;
   localparam int MAX_HEIGHT = 256;
   localparam int COL_W      = $clog2(MAX_WIDTH);
   localparam int ROW_W      = $clog2(MAX_HEIGHT);
   localparam int NUM_BANKS  = 4;
   localparam int BANK_SEL_W = 2;
   localparam int BANK_DEPTH = (MAX_WIDTH / 2) * (MAX_HEIGHT / 2);
   localparam int BANK_AW    = (COL_W - 1) + (ROW_W - 1);

   // Field widths.
   localparam int PIX_W     = 32;
   localparam int NUM_CH    = 4;
   localparam int CH_W      = 8;
   localparam int SRC_CRD_W = 8;
   localparam int DST_CRD_W = 12;
   localparam int STEP_W    = 24;
   localparam int SIZE_W    = 9;
   localparam int NCH_W     = 3;
   localparam int POS_W     = DST_CRD_W + STEP_W;
   localparam int FRAC_LSB  = 8;
   localparam int INT_LSB   = 16;
   localparam int IP_W      = POS_W - INT_LSB;
   localparam int FRAC_W    = 8;
   localparam int WGT_W     = FRAC_W + 1;
   localparam int BLEND_W   = 2 * CH_W;

   // Configuration port.
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 24;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_SRC_WIDTH  = 3'd0,
      CSR_SRC_HEIGHT = 3'd1,
      CSR_CHANNELS   = 3'd2,
      CSR_X_STEP     = 3'd3,
      CSR_Y_STEP     = 3'd4
   } csr_index_type;

   typedef enum logic {
      OP_LOAD   = 1'b0,
      OP_SAMPLE = 1'b1
   } op_type;

   // The four neighbors of one sample: near/far column by near/far row.
   typedef struct packed {
      logic [PIX_W-1:0] p00;
      logic [PIX_W-1:0] p10;
      logic [PIX_W-1:0] p01;
      logic [PIX_W-1:0] p11;
   } quad_type;

endpackage

// ===== rtl/bilinear_image_scaler_top.sv =====
// Bilinear image scaler with a banked source frame store.
//
// Input channel (req_*): each word is either a load, which writes req_src_pixel
// into the frame store at (req_src_row, req_src_col), or a sample, which asks
// for the interpolated pixel at destination (req_dst_col, req_dst_row).
// Result channel (rsp_*): one word per sample, none per load, in input order.
// Configuration (csr_*): one register write per cycle with csr_we high; write
// only while the pipeline is empty.
//
// The datapath is a six-stage pipeline: input register, position multiply,
// neighbor locate and store access, store read data, horizontal blend, and
// vertical blend into the output register. One word can be accepted every
// cycle while the receiver does not stall.
// The four neighbors come from four banks split by row and column parity, so
// each bank is read once per sample and the store never limits the rate.
//
// When the receiver stalls, the whole pipeline holds; req_ready stays high as
// long as the output register is empty or is being drained in that cycle.
// Reset clears the valid bits and restores the configuration defaults. The
// frame store is not cleared: a pixel must be loaded before it is sampled.
module bilinear_image_scaler_top
   import bis_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,

   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic                  req_operation,
   input  logic [SRC_CRD_W-1:0]  req_src_col,
   input  logic [SRC_CRD_W-1:0]  req_src_row,
   input  logic [PIX_W-1:0]      req_src_pixel,
   input  logic [DST_CRD_W-1:0]  req_dst_col,
   input  logic [DST_CRD_W-1:0]  req_dst_row,

   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [PIX_W-1:0]      rsp_out_pixel,

   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   // ---------------------------------------------------------------------
   // Configuration registers
   // ---------------------------------------------------------------------
   logic [SIZE_W-1:0] src_width_ff;
   logic [SIZE_W-1:0] src_height_ff;
   logic [NCH_W-1:0]  channels_ff;
   logic [STEP_W-1:0] x_step_ff;
   logic [STEP_W-1:0] y_step_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         src_width_ff  <= SIZE_W'(1);
         src_height_ff <= SIZE_W'(1);
         channels_ff   <= NCH_W'(NUM_CH);
         x_step_ff     <= '0;
         y_step_ff     <= '0;
      end else if (csr_we) begin
         case (csr_index)
            CSR_SRC_WIDTH:  src_width_ff  <= csr_wdata[SIZE_W-1:0];
            CSR_SRC_HEIGHT: src_height_ff <= csr_wdata[SIZE_W-1:0];
            CSR_CHANNELS:   channels_ff   <= csr_wdata[NCH_W-1:0];
            CSR_X_STEP:     x_step_ff     <= csr_wdata[STEP_W-1:0];
            CSR_Y_STEP:     y_step_ff     <= csr_wdata[STEP_W-1:0];
            default: ;
         endcase
      end
   end

   // Last valid column and row. A size of zero acts as one, and a size past
   // the store acts as the store's size.
   logic [COL_W-1:0]  last_col;
   logic [ROW_W-1:0]  last_row;
   logic [NCH_W-1:0]  nch;
   logic [NUM_CH-1:0] ch_en;

   always_comb begin
      if (src_width_ff == '0) begin
         last_col = '0;
      end else if (int'(src_width_ff) > MAX_WIDTH) begin
         last_col = COL_W'(MAX_WIDTH - 1);
      end else begin
         last_col = COL_W'(src_width_ff - 1'b1);
      end
      if (src_height_ff == '0) begin
         last_row = '0;
      end else if (int'(src_height_ff) > MAX_HEIGHT) begin
         last_row = ROW_W'(MAX_HEIGHT - 1);
      end else begin
         last_row = ROW_W'(src_height_ff - 1'b1);
      end
      // Channel count zero acts as one; counts past four act as four.
      if (channels_ff == '0) begin
         nch = NCH_W'(1);
      end else if (int'(channels_ff) > NUM_CH) begin
         nch = NCH_W'(NUM_CH);
      end else begin
         nch = channels_ff;
      end
      for (int c = 0; c < NUM_CH; c++) begin
         ch_en[c] = (c < int'(nch));
      end
   end

   // ---------------------------------------------------------------------
   // Pipeline control: every stage moves together whenever the output
   // register is empty or is being taken.
   // ---------------------------------------------------------------------
   logic advance;
   logic sv5_ff;

   assign advance   = !sv5_ff || rsp_ready;
   assign req_ready = advance;
   assign rsp_valid = sv5_ff;

   // Stage 0: input register.
   logic                 v0_ff;
   logic                 op0_ff;
   logic [SRC_CRD_W-1:0] ld_col0_ff;
   logic [SRC_CRD_W-1:0] ld_row0_ff;
   logic [PIX_W-1:0]     ld_pix0_ff;
   logic [DST_CRD_W-1:0] dst_col0_ff;
   logic [DST_CRD_W-1:0] dst_row0_ff;

   // Stage 1: source position in Q20.16.
   logic                 v1_ff;
   logic                 op1_ff;
   logic [SRC_CRD_W-1:0] ld_col1_ff;
   logic [SRC_CRD_W-1:0] ld_row1_ff;
   logic [PIX_W-1:0]     ld_pix1_ff;
   logic [POS_W-1:0]     pos_x_in;
   logic [POS_W-1:0]     pos_y_in;
   logic [POS_W-1:0]     pos_x_ff;
   logic [POS_W-1:0]     pos_y_ff;

   // Stage 2: neighbor coordinates and fractions; the store is accessed here.
   logic                 v2_ff;
   logic                 op2_ff;
   logic [SRC_CRD_W-1:0] ld_col2_ff;
   logic [SRC_CRD_W-1:0] ld_row2_ff;
   logic [PIX_W-1:0]     ld_pix2_ff;
   logic [COL_W-1:0]     x0_in, x1_in, x0_ff, x1_ff;
   logic [ROW_W-1:0]     y0_in, y1_in, y0_ff, y1_ff;
   logic [FRAC_W-1:0]    fx2_ff, fy2_ff;

   // Stage 3: store read data plus the parities that pick the banks apart.
   logic                 sv3_ff;
   logic                 x0p3_ff, x1p3_ff, y0p3_ff, y1p3_ff;
   logic [FRAC_W-1:0]    fx3_ff, fy3_ff;

   // Stage 4: horizontal blend (inside the blend unit).
   logic                 sv4_ff;

   assign pos_x_in = POS_W'(dst_col0_ff) * POS_W'(x_step_ff);
   assign pos_y_in = POS_W'(dst_row0_ff) * POS_W'(y_step_ff);

   // Near neighbor saturates at the last column/row; the far one is the next
   // column/row, clamped to the last.
   always_comb begin
      logic [IP_W-1:0] ip_x;
      logic [IP_W-1:0] ip_y;
      ip_x = pos_x_ff[POS_W-1:INT_LSB];
      ip_y = pos_y_ff[POS_W-1:INT_LSB];
      x0_in = (ip_x > IP_W'(last_col)) ? last_col : COL_W'(ip_x);
      y0_in = (ip_y > IP_W'(last_row)) ? last_row : ROW_W'(ip_y);
      x1_in = (x0_in == last_col) ? last_col : COL_W'(x0_in + 1'b1);
      y1_in = (y0_in == last_row) ? last_row : ROW_W'(y0_in + 1'b1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v0_ff  <= 1'b0;
         v1_ff  <= 1'b0;
         v2_ff  <= 1'b0;
         sv3_ff <= 1'b0;
         sv4_ff <= 1'b0;
         sv5_ff <= 1'b0;
      end else if (advance) begin
         v0_ff  <= req_valid;
         v1_ff  <= v0_ff;
         v2_ff  <= v1_ff;
         sv3_ff <= v2_ff && (op2_ff == OP_SAMPLE);
         sv4_ff <= sv3_ff;
         sv5_ff <= sv4_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         op0_ff      <= req_operation;
         ld_col0_ff  <= req_src_col;
         ld_row0_ff  <= req_src_row;
         ld_pix0_ff  <= req_src_pixel;
         dst_col0_ff <= req_dst_col;
         dst_row0_ff <= req_dst_row;

         op1_ff     <= op0_ff;
         ld_col1_ff <= ld_col0_ff;
         ld_row1_ff <= ld_row0_ff;
         ld_pix1_ff <= ld_pix0_ff;
         pos_x_ff   <= pos_x_in;
         pos_y_ff   <= pos_y_in;

         op2_ff     <= op1_ff;
         ld_col2_ff <= ld_col1_ff;
         ld_row2_ff <= ld_row1_ff;
         ld_pix2_ff <= ld_pix1_ff;
         x0_ff      <= x0_in;
         x1_ff      <= x1_in;
         y0_ff      <= y0_in;
         y1_ff      <= y1_in;
         fx2_ff     <= pos_x_ff[FRAC_LSB +: FRAC_W];
         fy2_ff     <= pos_y_ff[FRAC_LSB +: FRAC_W];

         x0p3_ff <= x0_ff[0];
         x1p3_ff <= x1_ff[0];
         y0p3_ff <= y0_ff[0];
         y1p3_ff <= y1_ff[0];
         fx3_ff  <= fx2_ff;
         fy3_ff  <= fy2_ff;
      end
   end

   // ---------------------------------------------------------------------
   // Frame store: bank {row parity, column parity}, address {row/2, col/2}.
   // Loads write and samples read in the same stage, so store accesses stay
   // in input order.
   // ---------------------------------------------------------------------
   logic [COL_W-1:0]   ld_col;
   logic [ROW_W-1:0]   ld_row;
   logic               ld_ok;
   logic [BANK_AW-1:0] waddr;
   logic [NUM_BANKS-1:0] bank_we;
   logic [BANK_AW-1:0] raddr [NUM_BANKS];
   logic [PIX_W-1:0]   bank_rdata [NUM_BANKS];

   assign ld_col = COL_W'(ld_col2_ff);
   assign ld_row = ROW_W'(ld_row2_ff);
   assign ld_ok  = (int'(ld_col2_ff) < MAX_WIDTH) && (int'(ld_row2_ff) < MAX_HEIGHT);
   assign waddr  = {ld_row[ROW_W-1:1], ld_col[COL_W-1:1]};

   for (genvar b = 0; b < NUM_BANKS; b++) begin : g_bank
      localparam logic RP = logic'(b / 2);
      localparam logic CP = logic'(b % 2);

      logic [COL_W-1:0] col_sel;
      logic [ROW_W-1:0] row_sel;

      // Of the two neighbor columns (rows), the one with this bank's parity;
      // when both are the same, the bank is either that one or unused.
      assign col_sel = (x0_ff[0] == CP) ? x0_ff : x1_ff;
      assign row_sel = (y0_ff[0] == RP) ? y0_ff : y1_ff;
      assign raddr[b] = {row_sel[ROW_W-1:1], col_sel[COL_W-1:1]};

      assign bank_we[b] = advance && v2_ff && (op2_ff == OP_LOAD) && ld_ok
                          && (ld_row[0] == RP) && (ld_col[0] == CP);

      bis_ram #(
         .WIDTH (PIX_W),
         .DEPTH (BANK_DEPTH)
      ) u_bank (
         .clock (clock),
         .we    (bank_we[b]),
         .waddr (waddr),
         .wdata (ld_pix2_ff),
         .re    (advance),
         .raddr (raddr[b]),
         .rdata (bank_rdata[b])
      );
   end

   // Put the bank outputs back into neighbor order.
   quad_type quad;

   assign quad.p00 = bank_rdata[{y0p3_ff, x0p3_ff}];
   assign quad.p10 = bank_rdata[{y0p3_ff, x1p3_ff}];
   assign quad.p01 = bank_rdata[{y1p3_ff, x0p3_ff}];
   assign quad.p11 = bank_rdata[{y1p3_ff, x1p3_ff}];

   bis_blend u_blend (
      .clock   (clock),
      .advance (advance),
      .quad    (quad),
      .fx      (fx3_ff),
      .fy      (fy3_ff),
      .ch_en   (ch_en),
      .pixel   (rsp_out_pixel)
   );

   // ---------------------------------------------------------------------
   // Assertions
   // ---------------------------------------------------------------------

   // A load writes at most one bank; a load outside the store writes none.
   a_one_bank_write: assert property (@(posedge clock) disable iff (reset)
      $onehot0(bank_we))
      else $error("load wrote more than one bank");

   // Neighbors stay inside the image and the far one is the near one or next.
   a_neighbors: assert property (@(posedge clock) disable iff (reset)
      (v2_ff && (op2_ff == OP_SAMPLE)) |->
         (x0_ff <= last_col) && (y0_ff <= last_row)
         && ((x1_ff == x0_ff) || (x1_ff == COL_W'(x0_ff + 1'b1)))
         && ((y1_ff == y0_ff) || (y1_ff == ROW_W'(y0_ff + 1'b1))))
      else $error("neighbor coordinates out of range");

   // A load never turns into a result word.
   a_load_no_result: assert property (@(posedge clock) disable iff (reset)
      (advance && v2_ff && (op2_ff == OP_LOAD)) |=> !sv3_ff)
      else $error("load produced a result");

   // A sample in the blend stage reaches the output register when it moves.
   a_sample_reaches_output: assert property (@(posedge clock) disable iff (reset)
      (advance && sv4_ff) |=> rsp_valid)
      else $error("sample lost before the output register");

endmodule

// ===== rtl/bis_ram.sv =====
module bis_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16384
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

// ===== rtl/bis_blend.sv =====
module bis_blend
   import bis_pkg::*;
(
   input  logic              clock,
   input  logic              advance,
   input  quad_type          quad,
   input  logic [FRAC_W-1:0] fx,
   input  logic [FRAC_W-1:0] fy,
   input  logic [NUM_CH-1:0] ch_en,
   output logic [PIX_W-1:0]  pixel
);

   logic [BLEND_W-1:0] top_in [NUM_CH];
   logic [BLEND_W-1:0] bot_in [NUM_CH];
   logic [BLEND_W-1:0] top_ff [NUM_CH];
   logic [BLEND_W-1:0] bot_ff [NUM_CH];
   logic [FRAC_W-1:0]  fy_ff;
   logic [PIX_W-1:0]   pixel_in;
   logic [PIX_W-1:0]   pixel_ff;
   logic [WGT_W-1:0]   wx_near;
   logic [WGT_W-1:0]   wy_near;

   // Horizontal pass: blend near and far column within each row.
   always_comb begin
      wx_near = WGT_W'(1 << FRAC_W) - {1'b0, fx};
      for (int c = 0; c < NUM_CH; c++) begin
         top_in[c] = BLEND_W'((BLEND_W + 1)'(quad.p00[c*CH_W +: CH_W]) * (BLEND_W + 1)'(wx_near)
                            + (BLEND_W + 1)'(quad.p10[c*CH_W +: CH_W]) * (BLEND_W + 1)'(fx));
         bot_in[c] = BLEND_W'((BLEND_W + 1)'(quad.p01[c*CH_W +: CH_W]) * (BLEND_W + 1)'(wx_near)
                            + (BLEND_W + 1)'(quad.p11[c*CH_W +: CH_W]) * (BLEND_W + 1)'(fx));
      end
   end

   // Vertical pass; the sum never exceeds 255 after dropping 16 fraction bits.
   always_comb begin
      logic [BLEND_W+WGT_W-1:0] acc;
      wy_near  = WGT_W'(1 << FRAC_W) - {1'b0, fy_ff};
      pixel_in = '0;
      for (int c = 0; c < NUM_CH; c++) begin
         acc = (BLEND_W + WGT_W)'(top_ff[c]) * (BLEND_W + WGT_W)'(wy_near)
             + (BLEND_W + WGT_W)'(bot_ff[c]) * (BLEND_W + WGT_W)'(fy_ff);
         if (ch_en[c]) begin
            pixel_in[c*CH_W +: CH_W] = acc[2*FRAC_W +: CH_W];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         for (int c = 0; c < NUM_CH; c++) begin
            top_ff[c] <= top_in[c];
            bot_ff[c] <= bot_in[c];
         end
         fy_ff    <= fy;
         pixel_ff <= pixel_in;
      end
   end

   assign pixel = pixel_ff;

endmodule
